### design/eat_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eat_pkg
// Shared types and constants for the extent address translator.
// ----------------------------------------------------------------------------
package eat_pkg;

    localparam int MAX_EXTENTS_DEFAULT = 64;
    localparam int BLOCK_W             = 36;
    localparam int BYTE_W              = 48;
    localparam int BLOCK_SHIFT         = 12;
    localparam int OP_W                = 2;
    localparam int STATUS_W            = 2;
    localparam int S_TDATA_W           = 208;
    localparam int M_TDATA_W           = 96;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR     = 2'd0,
        OP_APPEND    = 2'd1,
        OP_TRANSLATE = 2'd2
    } op_t;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERRUN  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNMAPPED = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] logical;
        logic [BYTE_W-1:0] physical;
        logic [BYTE_W-1:0] length;
    } extent_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_FETCH,
        ST_MATCH,
        ST_EMIT,
        ST_FLUSH
    } state_t;

endpackage : eat_pkg
`default_nettype wire

### design/extent_address_translator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// extent_address_translator
// Extent map that turns a logical byte range into physical byte chunks.
// ----------------------------------------------------------------------------
// Clear and append transactions produce no result; an append to a full
// table is dropped. A translate transaction scans the extent table from
// entry zero through the table memory's registered read port: every entry
// scanned takes an address step, a read-data step and a match step, every
// chunk found takes one more step, and a final step finishes the last chunk;
// any output stall adds to the time of a request. Each chunk is held in a
// pending register so that the final one can carry last and its status; a
// result waits in the output register while the next transaction is taken.
// ----------------------------------------------------------------------------
module extent_address_translator #(
    parameter int MAX_EXTENTS = eat_pkg::MAX_EXTENTS_DEFAULT
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // [35:0] ext_logical_block, [71:36] ext_physical_block,
    // [107:72] ext_block_count, [155:108] req_offset, [203:156] req_length
    input  wire  [eat_pkg::S_TDATA_W-1:0]     s_tdata,
    // [1:0] op
    input  wire  [eat_pkg::OP_W-1:0]          s_tuser,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // [47:0] chunk_offset, [95:48] chunk_length
    output logic [eat_pkg::M_TDATA_W-1:0]     m_tdata,
    // [1:0] status
    output logic [eat_pkg::STATUS_W-1:0]      m_tuser,
    output logic                              m_tlast
);

    localparam int IDX_W = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
    localparam int BW    = eat_pkg::BYTE_W;

    eat_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]             count_reg, count_next;
    logic [IDX_W-1:0]             idx_reg, idx_next;
    logic [BW-1:0]                off_reg, off_next;
    logic [BW-1:0]                rem_reg, rem_next;
    logic                         started_reg, started_next;
    logic [BW:0]                  end_reg, end_next;
    logic [BW:0]                  diff_reg, diff_next;
    logic                         lenz_reg, lenz_next;
    logic [BW-1:0]                phys_reg, phys_next;
    logic [BW-1:0]                avail_reg, avail_next;

    logic                         pend_valid_reg, pend_valid_next;
    logic [BW-1:0]                pend_off_reg, pend_off_next;
    logic [BW-1:0]                pend_len_reg, pend_len_next;
    logic [eat_pkg::STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic                         pend_last_reg, pend_last_next;

    logic                         out_valid_reg, out_valid_next;
    logic [BW-1:0]                out_off_reg, out_off_next;
    logic [BW-1:0]                out_len_reg, out_len_next;
    logic [eat_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic                         out_last_reg, out_last_next;

    logic                         s_accept;
    eat_pkg::op_t                 in_op;
    logic [eat_pkg::BLOCK_W-1:0]  in_lblk, in_pblk, in_nblk;
    logic [BW-1:0]                in_offset, in_length;

    logic                         wr_en;
    eat_pkg::extent_t             wr_data;
    eat_pkg::extent_t             rd_data;

    logic                         out_free;
    logic                         hit;
    logic                         last_entry;
    logic                         table_full;
    logic [BW:0]                  rem_diff;
    logic                         fin;

    assign in_op     = eat_pkg::op_t'(s_tuser);
    assign in_lblk   = s_tdata[35:0];
    assign in_pblk   = s_tdata[71:36];
    assign in_nblk   = s_tdata[107:72];
    assign in_offset = s_tdata[155:108];
    assign in_length = s_tdata[203:156];

    assign s_tready = (state_reg == eat_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign table_full = (count_reg == CNT_W'(MAX_EXTENTS));
    assign wr_en      = s_accept && (in_op == eat_pkg::OP_APPEND) && !table_full;

    assign wr_data.logical  = {in_lblk, {eat_pkg::BLOCK_SHIFT{1'b0}}};
    assign wr_data.physical = {in_pblk, {eat_pkg::BLOCK_SHIFT{1'b0}}};
    assign wr_data.length   = {in_nblk, {eat_pkg::BLOCK_SHIFT{1'b0}}};

    eat_extent_store #(
        .MAX_EXTENTS(MAX_EXTENTS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (wr_data),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign out_free   = !out_valid_reg || m_tready;
    assign hit        = !diff_reg[BW] && ({1'b0, off_reg} < end_reg);
    assign last_entry = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign rem_diff   = {1'b0, rem_reg} - {1'b0, avail_reg};
    assign fin        = rem_diff[BW] || (rem_diff == '0);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            eat_pkg::ST_IDLE: begin
                if (s_accept && (in_op == eat_pkg::OP_TRANSLATE)) begin
                    state_next = (count_reg == '0) ? eat_pkg::ST_FLUSH : eat_pkg::ST_READ;
                end
            end
            eat_pkg::ST_READ: begin
                state_next = eat_pkg::ST_FETCH;
            end
            eat_pkg::ST_FETCH: begin
                state_next = eat_pkg::ST_MATCH;
            end
            eat_pkg::ST_MATCH: begin
                if ((!started_reg && !hit) || (started_reg && lenz_reg)) begin
                    state_next = last_entry ? eat_pkg::ST_FLUSH : eat_pkg::ST_READ;
                end else begin
                    state_next = eat_pkg::ST_EMIT;
                end
            end
            eat_pkg::ST_EMIT: begin
                if (!pend_valid_reg || out_free) begin
                    if (fin || last_entry) begin
                        state_next = eat_pkg::ST_FLUSH;
                    end else begin
                        state_next = eat_pkg::ST_READ;
                    end
                end
            end
            eat_pkg::ST_FLUSH: begin
                if (out_free) begin
                    state_next = eat_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = eat_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        count_next       = count_reg;
        idx_next         = idx_reg;
        off_next         = off_reg;
        rem_next         = rem_reg;
        started_next     = started_reg;
        end_next         = end_reg;
        diff_next        = diff_reg;
        lenz_next        = lenz_reg;
        phys_next        = phys_reg;
        avail_next       = avail_reg;
        pend_valid_next  = pend_valid_reg;
        pend_off_next    = pend_off_reg;
        pend_len_next    = pend_len_reg;
        pend_status_next = pend_status_reg;
        pend_last_next   = pend_last_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_off_next     = out_off_reg;
        out_len_next     = out_len_reg;
        out_status_next  = out_status_reg;
        out_last_next    = out_last_reg;

        case (state_reg)
            eat_pkg::ST_IDLE: begin
                if (s_accept) begin
                    case (in_op)
                        eat_pkg::OP_CLEAR: begin
                            count_next = '0;
                        end
                        eat_pkg::OP_APPEND: begin
                            if (!table_full) begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        eat_pkg::OP_TRANSLATE: begin
                            idx_next        = '0;
                            off_next        = in_offset;
                            rem_next        = in_length;
                            started_next    = 1'b0;
                            pend_valid_next = 1'b0;
                            // empty table: report an unmapped start
                            pend_off_next    = '0;
                            pend_len_next    = '0;
                            pend_status_next = eat_pkg::STATUS_UNMAPPED;
                            pend_last_next   = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            eat_pkg::ST_FETCH: begin
                end_next  = {1'b0, rd_data.logical} + {1'b0, rd_data.length};
                diff_next = {1'b0, off_reg} - {1'b0, rd_data.logical};
                lenz_next = (rd_data.length == '0);
            end
            eat_pkg::ST_MATCH: begin
                if (!started_reg) begin
                    phys_next  = rd_data.physical + diff_reg[BW-1:0];
                    avail_next = BW'(end_reg - {1'b0, off_reg});
                    if (hit) begin
                        started_next = 1'b1;
                    end
                end else begin
                    phys_next  = rd_data.physical;
                    avail_next = rd_data.length;
                end
                if ((!started_reg && !hit) || (started_reg && lenz_reg)) begin
                    idx_next = idx_reg + IDX_W'(1);
                    if (last_entry) begin
                        if (started_reg) begin
                            pend_status_next = eat_pkg::STATUS_OVERRUN;
                            pend_last_next   = 1'b1;
                        end else begin
                            pend_off_next    = '0;
                            pend_len_next    = '0;
                            pend_status_next = eat_pkg::STATUS_UNMAPPED;
                            pend_last_next   = 1'b1;
                        end
                    end
                end
            end
            eat_pkg::ST_EMIT: begin
                if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        out_valid_next  = 1'b1;
                        out_off_next    = pend_off_reg;
                        out_len_next    = pend_len_reg;
                        out_status_next = pend_status_reg;
                        out_last_next   = pend_last_reg;
                    end
                    pend_valid_next = 1'b1;
                    pend_off_next   = phys_reg;
                    if (fin) begin
                        pend_len_next    = rem_reg;
                        pend_status_next = eat_pkg::STATUS_OK;
                        pend_last_next   = 1'b1;
                    end else begin
                        pend_len_next    = avail_reg;
                        pend_status_next = last_entry ? eat_pkg::STATUS_OVERRUN
                                                      : eat_pkg::STATUS_OK;
                        pend_last_next   = last_entry;
                        rem_next         = rem_diff[BW-1:0];
                        idx_next         = idx_reg + IDX_W'(1);
                    end
                end
            end
            eat_pkg::ST_FLUSH: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_off_next    = pend_off_reg;
                    out_len_next    = pend_len_reg;
                    out_status_next = pend_status_reg;
                    out_last_next   = pend_last_reg;
                    pend_valid_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= eat_pkg::ST_IDLE;
            count_reg      <= '0;
            started_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            started_reg    <= started_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg         <= idx_next;
        off_reg         <= off_next;
        rem_reg         <= rem_next;
        end_reg         <= end_next;
        diff_reg        <= diff_next;
        lenz_reg        <= lenz_next;
        phys_reg        <= phys_next;
        avail_reg       <= avail_next;
        pend_off_reg    <= pend_off_next;
        pend_len_reg    <= pend_len_next;
        pend_status_reg <= pend_status_next;
        pend_last_reg   <= pend_last_next;
        out_off_reg     <= out_off_next;
        out_len_reg     <= out_len_next;
        out_status_reg  <= out_status_next;
        out_last_reg    <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_len_reg, out_off_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule : extent_address_translator
`default_nettype wire

### design/eat_extent_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eat_extent_store
// Extent table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module eat_extent_store #(
    parameter int MAX_EXTENTS = eat_pkg::MAX_EXTENTS_DEFAULT
) (
    input  wire                                                   aclk,
    input  wire                                                   wr_en,
    input  wire [((MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1)-1:0] wr_addr,
    input  wire eat_pkg::extent_t                                 wr_data,
    input  wire [((MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1)-1:0] rd_addr,
    output eat_pkg::extent_t                                      rd_data
);

    eat_pkg::extent_t mem [MAX_EXTENTS];
    eat_pkg::extent_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule : eat_extent_store
`default_nettype wire
